[sv/bbsf_pkg.sv]
// Shared types, constants and helpers for the bounded byte stream FIFO.
// No dependencies; every other file of the block uses this package.
package bbsf_pkg;

  localparam int unsigned DEPTH   = 4096;
  localparam int unsigned MAX_RUN = 64;
  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned RUN_W   = $clog2(MAX_RUN + 1);
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned TOT_W   = 64;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_END   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_END,
    OP_EMPTY,
    OP_FIRST,
    OP_NEXT
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    op_e  op;
    logic pop;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic can_load;
    logic n_zero;
    logic n_one;
    logic rem_one;
  } stat_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

[sv/bbsf_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on bbsf_pkg for field widths.
interface bbsf_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [7:0]                    write_data;
  logic [bbsf_pkg::LEN_W-1:0]    request_length;

  modport source (output valid, req_type, write_data, request_length, input ready);
  modport sink   (input valid, req_type, write_data, request_length, output ready);
endinterface

interface bbsf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    out_byte;
  logic                          byte_valid;
  logic                          last_of_run;
  logic                          write_accepted;
  logic [bbsf_pkg::CNT_W-1:0]    occupancy;
  logic [bbsf_pkg::CNT_W-1:0]    free_space;
  logic                          ended;
  logic                          end_of_stream;
  logic [bbsf_pkg::TOT_W-1:0]    total_written;
  logic [bbsf_pkg::TOT_W-1:0]    total_read;

  modport source (output valid, out_byte, byte_valid, last_of_run, write_accepted,
                  occupancy, free_space, ended, end_of_stream, total_written,
                  total_read, input ready);
  modport sink   (input valid, out_byte, byte_valid, last_of_run, write_accepted,
                  occupancy, free_space, ended, end_of_stream, total_written,
                  total_read, output ready);
endinterface

[sv/bbsf_ctrl.sv]
// Request sequencer: decodes requests and steps read and peek runs.
// Depends on bbsf_pkg; drives commands into bbsf_dp and reads its status.
module bbsf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic [1:0]        req_type_i,
  output logic              req_ready_o,
  input  bbsf_pkg::stat_t   stat_i,
  output bbsf_pkg::cmd_t    cmd_o
);
  import bbsf_pkg::*;

  state_e state_q, state_d;
  logic   pop_q, pop_d;
  req_e   req;

  assign req = req_e'(req_type_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pop_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pop_q   <= pop_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pop_d       = pop_q;
    req_ready_o = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.pop   = 1'b0;
    cmd_o.last  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = stat_i.can_load;
        if (req_valid_i && stat_i.can_load) begin
          case (req)
            REQ_WRITE: cmd_o.op = OP_WRITE;
            REQ_END:   cmd_o.op = OP_END;
            REQ_READ, REQ_PEEK: begin
              if (stat_i.n_zero) begin
                cmd_o.op = OP_EMPTY;
              end else begin
                cmd_o.op   = OP_FIRST;
                cmd_o.pop  = (req == REQ_READ);
                cmd_o.last = stat_i.n_one;
                pop_d      = (req == REQ_READ);
                if (!stat_i.n_one) begin
                  state_d = ST_RUN;
                end
              end
            end
            default: cmd_o.op = OP_NONE;
          endcase
        end
      end
      ST_RUN: begin
        if (stat_i.can_load) begin
          cmd_o.op   = OP_NEXT;
          cmd_o.pop  = pop_q;
          cmd_o.last = stat_i.rem_one;
          if (stat_i.rem_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[sv/bbsf_dp.sv]
// Datapath: byte store, pointers, counters, capacity and the result register.
// Depends on bbsf_pkg; commanded by bbsf_ctrl.
module bbsf_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bbsf_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic [7:0]                  write_data_i,
  input  logic [bbsf_pkg::LEN_W-1:0]  request_length_i,
  input  bbsf_pkg::cmd_t              cmd_i,
  output bbsf_pkg::stat_t             stat_o,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output logic [7:0]                  out_byte_o,
  output logic                        byte_valid_o,
  output logic                        last_of_run_o,
  output logic                        write_accepted_o,
  output logic [bbsf_pkg::CNT_W-1:0]  occupancy_o,
  output logic [bbsf_pkg::CNT_W-1:0]  free_space_o,
  output logic                        ended_o,
  output logic                        end_of_stream_o,
  output logic [bbsf_pkg::TOT_W-1:0]  total_written_o,
  output logic [bbsf_pkg::TOT_W-1:0]  total_read_o
);
  import bbsf_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rdata_q;

  logic [CNT_W-1:0] cap_q;
  logic [PTR_W-1:0] head_q, tail_q, rd_ptr_q;
  logic [CNT_W-1:0] fill_q;
  logic [TOT_W-1:0] wr_tot_q, rd_tot_q;
  logic             ended_q;
  logic [RUN_W-1:0] rem_q;
  logic             slot_q, bvalid_q, last_q, wacc_q;

  logic [CNT_W-1:0] eff_cap;
  logic             space;
  logic [LEN_W-1:0] len_c;
  logic [RUN_W-1:0] run_n;
  logic             load, is_byte, mem_we;
  logic [PTR_W-1:0] rd_addr;

  assign eff_cap = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;
  assign space   = fill_q < eff_cap;
  assign len_c   = (request_length_i > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN) : request_length_i;
  assign run_n   = (fill_q < CNT_W'(len_c)) ? RUN_W'(fill_q) : RUN_W'(len_c);

  assign load    = (cmd_i.op != OP_NONE);
  assign is_byte = (cmd_i.op == OP_FIRST) || (cmd_i.op == OP_NEXT);
  assign mem_we  = (cmd_i.op == OP_WRITE) && space;
  assign rd_addr = (cmd_i.op == OP_FIRST) ? head_q : rd_ptr_q;

  assign stat_o.can_load = !slot_q || rsp_ready_i;
  assign stat_o.n_zero   = (run_n == '0);
  assign stat_o.n_one    = (run_n == RUN_W'(1));
  assign stat_o.rem_one  = (rem_q == RUN_W'(1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= write_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_byte) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bvalid_q <= is_byte;
      last_q   <= cmd_i.last;
      wacc_q   <= mem_we;
    end
    if (cmd_i.op == OP_FIRST) begin
      rem_q <= run_n - RUN_W'(1);
    end else if (cmd_i.op == OP_NEXT) begin
      rem_q <= rem_q - RUN_W'(1);
    end
    if (is_byte) begin
      rd_ptr_q <= next_ptr(rd_addr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CNT_W'(4096);
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      wr_tot_q <= '0;
      rd_tot_q <= '0;
      ended_q  <= 1'b0;
      slot_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (load) begin
        slot_q <= 1'b1;
      end else if (rsp_ready_i) begin
        slot_q <= 1'b0;
      end
      if (mem_we) begin
        tail_q   <= next_ptr(tail_q);
        fill_q   <= fill_q + CNT_W'(1);
        wr_tot_q <= wr_tot_q + TOT_W'(1);
      end
      if (cmd_i.op == OP_END) begin
        ended_q <= 1'b1;
      end
      if (is_byte && cmd_i.pop) begin
        head_q   <= next_ptr(rd_addr);
        fill_q   <= fill_q - CNT_W'(1);
        rd_tot_q <= rd_tot_q + TOT_W'(1);
      end
    end
  end

  assign rsp_valid_o      = slot_q;
  assign out_byte_o       = bvalid_q ? rdata_q : 8'd0;
  assign byte_valid_o     = bvalid_q;
  assign last_of_run_o    = last_q;
  assign write_accepted_o = wacc_q;
  assign occupancy_o      = fill_q;
  assign free_space_o     = space ? eff_cap - fill_q : '0;
  assign ended_o          = ended_q;
  assign end_of_stream_o  = ended_q && (fill_q == '0);
  assign total_written_o  = wr_tot_q;
  assign total_read_o     = rd_tot_q;

endmodule

[sv/bounded_byte_stream_fifo.sv]
// Top level of the bounded byte stream FIFO: sequencer plus datapath.
// Depends on bbsf_pkg, bbsf_if, bbsf_ctrl and bbsf_dp.
//
//   channel  dir  payload                                   transfer
//   req_i    in   req_type, write_data, request_length      valid && ready
//   rsp_o    out  byte, flags, occupancy, space, totals     valid && ready
//   cfg      in   capacity (13 bits)                        cfg_we_i
//
// Write, end and empty requests can follow back to back while results are taken.
// A read or peek of n bytes gives n byte results, one store read port access per byte.
// Reset clears head and tail pointers, fill and total counters and the ended flag, and sets capacity to 4096;
// store is not cleared. A stalled result holds the run and blocks new requests until it is taken.
module bounded_byte_stream_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bbsf_pkg::CNT_W-1:0]  cfg_wdata_i,
  bbsf_req_if.sink                    req_i,
  bbsf_rsp_if.source                  rsp_o
);
  import bbsf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bbsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bbsf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .write_data_i     (req_i.write_data),
    .request_length_i (req_i.request_length),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .out_byte_o       (rsp_o.out_byte),
    .byte_valid_o     (rsp_o.byte_valid),
    .last_of_run_o    (rsp_o.last_of_run),
    .write_accepted_o (rsp_o.write_accepted),
    .occupancy_o      (rsp_o.occupancy),
    .free_space_o     (rsp_o.free_space),
    .ended_o          (rsp_o.ended),
    .end_of_stream_o  (rsp_o.end_of_stream),
    .total_written_o  (rsp_o.total_written),
    .total_read_o     (rsp_o.total_read)
  );

endmodule

[sv/bbsf_checker.sv]
// Port-level checks for bounded_byte_stream_fifo, attached by bind.
// Depends on bbsf_pkg for widths.
module bbsf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [7:0]                  out_byte_i,
  input logic                        byte_valid_i,
  input logic                        last_of_run_i,
  input logic                        write_accepted_i,
  input logic [bbsf_pkg::CNT_W-1:0]  occupancy_i,
  input logic                        ended_i,
  input logic                        end_of_stream_i
);
  import bbsf_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(out_byte_i)
      && $stable(last_of_run_i) && $stable(byte_valid_i))
    else $error("result changed while stalled");

  a_byte_not_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && byte_valid_i |-> !write_accepted_i)
    else $error("byte result flagged as accepted write");

  a_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && end_of_stream_i |-> ended_i && (occupancy_i == '0))
    else $error("end of stream without ended and empty buffer");

  a_no_req_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !last_of_run_i |-> !req_ready_i)
    else $error("request taken in the middle of a run");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_ready_i && !last_of_run_i |=> rsp_valid_i && byte_valid_i)
    else $error("run stopped before its last byte");

endmodule

bind bounded_byte_stream_fifo bbsf_checker u_bbsf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .out_byte_i       (rsp_o.out_byte),
  .byte_valid_i     (rsp_o.byte_valid),
  .last_of_run_i    (rsp_o.last_of_run),
  .write_accepted_i (rsp_o.write_accepted),
  .occupancy_i      (rsp_o.occupancy),
  .ended_i          (rsp_o.ended),
  .end_of_stream_i  (rsp_o.end_of_stream)
);
